// ===== rtl/core/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key table package
// Field widths, operation and status codes, and the transaction payload types
// shared by the sorted key table, its stream interface and its checker.
// ----------------------------------------------------------------------------
package skt_pkg;

    // Payload field widths
    localparam int KEY_W  = 32;
    localparam int OP_W   = 3;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 3;
    localparam int FILL_W = 7;

    // Default table depth
    localparam int DEFAULT_CAPACITY = 64;

    // Operation codes; the two highest codes are unused and do nothing
    localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND        = 3'd3;
    localparam logic [OP_W-1:0] OP_READ        = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LO    = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI    = 3'd7;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    // Request transaction
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] key_in;
        logic [IDX_W-1:0]        index_in;
    } req_item_t;

    // Response transaction
    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [IDX_W-1:0]        index_out;
        logic [STAT_W-1:0]       status;
        logic [FILL_W-1:0]       fill_level;
    } rsp_item_t;

endpackage

// ===== rtl/core/skt_stream_if.sv =====
// ----------------------------------------------------------------------------
// Sorted key table stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface skt_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    // Producer side
    modport source (
        output valid,
        output payload,
        input  ready
    );

    // Consumer side
    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== rtl/core/sorted_key_table.sv =====
// Request to response: a read passes a wait and a capture state; a find runs the binary
// search, then a wait and a check state; remove-at moves any later entries down; insert
// runs the search, moves any later entries up and writes the key; all else, errors included, goes to done.
// A response that is not taken holds the sequencer in its last state.
// Throughput: one transaction at a time; the key memory's single read port and the shared
// 32-bit comparator set the figure (one shifted entry or half a search step per cycle).
// Reset: asynchronous, active low; empties the table; the key memory is not cleared.
// ----------------------------------------------------------------------------
// Sorted key table
// Keeps signed Q16.16 keys in ascending order in a single memory and serves
// insert, remove, find and read transactions with a small sequencer.
// ----------------------------------------------------------------------------
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::DEFAULT_CAPACITY
) (
    input  logic         clk,
    input  logic         rst_n,
    skt_stream_if.sink   req,
    skt_stream_if.source rsp
);
    import skt_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EXT_W  = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_FLUSH,
        S_INS_WR,
        S_READ_WAIT,
        S_READ_CAP,
        S_FIND_WAIT,
        S_FIND_CHK,
        S_DONE
    } state_t;

    // Key memory
    logic signed [KEY_W-1:0] key_mem [CAPACITY];
    logic signed [KEY_W-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [ADDR_W-1:0]       mem_waddr;
    logic signed [KEY_W-1:0] mem_wdata;
    logic                    mem_we;

    // Sequencer state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]       ptr_reg, ptr_next;
    logic                    wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]       wr_addr_reg, wr_addr_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;

    // Result being built and the response register
    logic signed [KEY_W-1:0] key_res_reg, key_res_next;
    logic [IDX_W-1:0]        idx_res_reg, idx_res_next;
    logic [STAT_W-1:0]       stat_reg, stat_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_item_reg, rsp_item_next;

    // Shared helpers
    logic [CNT_W-1:0]        mid;
    logic [EXT_W-1:0]        cnt_ext;
    logic [EXT_W-1:0]        cnt_dec_ext;
    logic [EXT_W-1:0]        idx_ext;
    logic [EXT_W-1:0]        idx_inc_ext;
    logic [EXT_W-1:0]        lo_ext;
    logic                    cmp_lt;
    logic                    cmp_eq;
    logic                    go_right;

    // The single key comparator, shared by search and find
    assign cmp_lt   = (mem_rdata_reg < key_reg);
    assign cmp_eq   = (mem_rdata_reg == key_reg);
    assign go_right = (op_reg == OP_INSERT) ? (cmp_lt || cmp_eq) : cmp_lt;

    assign mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cnt_ext     = EXT_W'(count_reg);
    assign cnt_dec_ext = cnt_ext - 1'b1;
    assign idx_ext     = EXT_W'(req.payload.index_in);
    assign idx_inc_ext = idx_ext + 1'b1;
    assign lo_ext      = EXT_W'(lo_reg);

    // Memory port selection
    assign mem_raddr = (state_reg == S_SEARCH) ? mid[ADDR_W-1:0] : ptr_reg;
    assign mem_we    = wr_pend_reg || (state_reg == S_INS_WR);
    assign mem_waddr = wr_pend_reg ? wr_addr_reg : lo_reg[ADDR_W-1:0];
    assign mem_wdata = wr_pend_reg ? mem_rdata_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= key_mem[mem_raddr];
    end

    // Handshake outputs
    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_item_reg;

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        key_res_next   = key_res_reg;
        idx_res_next   = idx_res_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;

        // A waiting response leaves once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.payload.operation;
                    key_next     = req.payload.key_in;
                    key_res_next = '0;
                    idx_res_next = '0;
                    stat_next    = STAT_OK;
                    lo_next      = '0;
                    hi_next      = count_reg;
                    state_next   = S_DONE;
                    case (req.payload.operation)
                        OP_INSERT:
                        begin
                            if (cnt_ext >= EXT_W'(CAPACITY))
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_REMOVE_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next   = count_reg - 1'b1;
                                idx_res_next = cnt_dec_ext[IDX_W-1:0];
                            end
                        end
                        OP_REMOVE_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (idx_ext >= cnt_ext)
                            begin
                                stat_next = STAT_RANGE;
                            end
                            else
                            begin
                                count_next   = count_reg - 1'b1;
                                idx_res_next = req.payload.index_in;
                                if (idx_inc_ext < cnt_ext)
                                begin
                                    ptr_next   = idx_inc_ext[ADDR_W-1:0];
                                    state_next = S_SHIFT_DN;
                                end
                            end
                        end
                        OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (idx_ext >= cnt_ext)
                            begin
                                stat_next = STAT_RANGE;
                            end
                            else
                            begin
                                idx_res_next = req.payload.index_in;
                                ptr_next     = idx_ext[ADDR_W-1:0];
                                state_next   = S_READ_WAIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Binary search: issue a read at the midpoint or finish
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ptr_next   = mid[ADDR_W-1:0];
                    state_next = S_COMPARE;
                end
                else if (op_reg == OP_INSERT)
                begin
                    if (lo_reg == count_reg)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        ptr_next   = cnt_dec_ext[ADDR_W-1:0];
                        state_next = S_SHIFT_UP;
                    end
                end
                else if (lo_reg < count_reg)
                begin
                    ptr_next   = lo_reg[ADDR_W-1:0];
                    state_next = S_FIND_WAIT;
                end
                else
                begin
                    stat_next  = STAT_NOTFOUND;
                    state_next = S_DONE;
                end
            end

            // Narrow the search window using the entry read at the midpoint
            S_COMPARE:
            begin
                if (go_right)
                begin
                    lo_next = CNT_W'(EXT_W'(ptr_reg) + 1'b1);
                end
                else
                begin
                    hi_next = CNT_W'(ptr_reg);
                end
                state_next = S_SEARCH;
            end

            // Move entries up one place, highest first, one per cycle
            S_SHIFT_UP:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = ptr_reg + 1'b1;
                if (ptr_reg == lo_reg[ADDR_W-1:0])
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
            end

            // Move entries down one place, lowest first, one per cycle
            S_SHIFT_DN:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = ptr_reg - 1'b1;
                if (EXT_W'(ptr_reg) == cnt_ext)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            // The last moved entry is written in this cycle
            S_FLUSH:
            begin
                state_next = (op_reg == OP_INSERT) ? S_INS_WR : S_DONE;
            end

            // Place the new key at its slot
            S_INS_WR:
            begin
                count_next   = count_reg + 1'b1;
                idx_res_next = lo_ext[IDX_W-1:0];
                state_next   = S_DONE;
            end

            S_READ_WAIT:
            begin
                state_next = S_READ_CAP;
            end

            S_READ_CAP:
            begin
                key_res_next = mem_rdata_reg;
                state_next   = S_DONE;
            end

            S_FIND_WAIT:
            begin
                state_next = S_FIND_CHK;
            end

            // Lower bound found; an exact match is required
            S_FIND_CHK:
            begin
                if (cmp_eq)
                begin
                    idx_res_next = lo_ext[IDX_W-1:0];
                end
                else
                begin
                    stat_next = STAT_NOTFOUND;
                end
                state_next = S_DONE;
            end

            // Hand the result to the response register once it is free
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_item_next.key_out    = key_res_reg;
                    rsp_item_next.index_out  = idx_res_reg;
                    rsp_item_next.status     = stat_reg;
                    rsp_item_next.fill_level = cnt_ext[FILL_W-1:0];
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        ptr_reg      <= ptr_next;
        wr_addr_reg  <= wr_addr_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        key_res_reg  <= key_res_next;
        idx_res_reg  <= idx_res_next;
        stat_reg     <= stat_next;
        rsp_item_reg <= rsp_item_next;
    end

endmodule

// ===== rtl/core/skt_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted key table checker
// Port-level assertions on the sorted key table, attached by a bind.
// ----------------------------------------------------------------------------
module skt_checker #(
    parameter int CAPACITY = skt_pkg::DEFAULT_CAPACITY
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic signed [skt_pkg::KEY_W-1:0]  rsp_key_out,
    input logic [skt_pkg::IDX_W-1:0]    rsp_index_out,
    input logic [skt_pkg::STAT_W-1:0]   rsp_status,
    input logic [skt_pkg::FILL_W-1:0]   rsp_fill_level
);
    import skt_pkg::*;

    // One transaction at a time: the request side closes right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while a transaction was in progress");

    // A failed operation reports neither a key nor an index
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_key_out == '0 && rsp_index_out == '0))
    else $error("error response carries a key or an index");

    // The fill level never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_fill_level) <= CAPACITY))
    else $error("fill level beyond capacity");

    // A full report comes only from a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == STAT_FULL) |-> (rsp_fill_level == FILL_W'(CAPACITY)))
    else $error("full status with free entries");

    // An empty report comes only from an empty table
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == STAT_EMPTY) |-> (rsp_fill_level == '0))
    else $error("empty status with stored entries");

endmodule

bind sorted_key_table skt_checker #(
    .CAPACITY(CAPACITY)
) u_skt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_key_out   (rsp.payload.key_out),
    .rsp_index_out (rsp.payload.index_out),
    .rsp_status    (rsp.payload.status),
    .rsp_fill_level(rsp.payload.fill_level)
);
